// ===== hw/rtl/ucfe_pkg.sv =====
// Shared types and constants for the serial command frame engine.
// Used by the parser, the output serializer and the top level.
package ucfe_pkg;

   // Largest reply payload the parser accepts (0 to 4 bytes).
   localparam logic [3:0] PAYLOAD_MAX = 4'd4;

   // Request types.
   localparam logic [1:0] REQ_SEND = 2'd0;
   localparam logic [1:0] REQ_BYTE = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_REPLY_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_ABORT_WINDOW  = 2'd1;
   localparam logic [1:0] CSR_PAYLOAD_LEN   = 2'd2;

   // Completion status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SYNC_TO   = 3'd1;
   localparam logic [2:0] ST_READ_TO   = 3'd2;
   localparam logic [2:0] ST_BAD_TAIL  = 3'd3;
   localparam logic [2:0] ST_CHECKSUM  = 3'd4;
   localparam logic [2:0] ST_SIZE      = 3'd5;
   localparam logic [2:0] ST_FUNCTION  = 3'd6;

   // Result kinds.
   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Frame bytes.
   localparam logic [7:0] SYNC_BYTE    = 8'hfe;
   localparam logic [7:0] CMD_LEN_BYTE = 8'h05;
   localparam logic [7:0] TAIL_BYTE    = 8'h16;
   localparam logic [7:0] LEN_OVERHEAD = 8'd3;
   localparam logic [16:0] ELAPSED_MAX = 17'h1ffff;

   // Frame byte positions.
   localparam logic [2:0] POS_SYNC0 = 3'd0;
   localparam logic [2:0] POS_SYNC1 = 3'd1;
   localparam logic [2:0] POS_LEN   = 3'd2;
   localparam logic [2:0] POS_FUNC  = 3'd3;
   localparam logic [2:0] POS_DH    = 3'd4;
   localparam logic [2:0] POS_DL    = 3'd5;
   localparam logic [2:0] POS_SUM   = 3'd6;
   localparam logic [2:0] POS_TAIL  = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_HUNT    = 3'd1,
      PH_LEN     = 3'd2,
      PH_FUNC    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_SUM     = 3'd5,
      PH_TAIL    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [15:0] reply_timeout_ms;
      logic [15:0] abort_window_ms;
      logic [2:0]  payload_len;
   } cfg_type;

   // What one accepted item asks of the output side.
   typedef struct packed {
      logic        frame;          // emit an 8-byte command frame
      logic        done;           // emit one completion
      logic [7:0]  func_code;
      logic [15:0] cmd_word;
      logic [2:0]  status;
      logic [31:0] payload_word;
      logic [2:0]  payload_count;
   } desc_type;

endpackage

// ===== hw/rtl/ucfe_parser.sv =====
// Reply parser and timeout tracking for the serial command frame engine.
// Depends on ucfe_pkg; updates its state once per accepted item.
module ucfe_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        req_type,
   input  logic [7:0]        func_code,
   input  logic [15:0]       cmd_word,
   input  logic [7:0]        rx_byte,
   input  ucfe_pkg::cfg_type cfg,
   output ucfe_pkg::desc_type desc
);

   ucfe_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic [7:0]  pending_fn_ff, pending_fn_in;
   logic [7:0]  length_ff, length_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [31:0] payload_acc_ff, payload_acc_in;
   logic [2:0]  byte_count_ff, byte_count_in;
   logic [7:0]  sum_acc_ff, sum_acc_in;
   logic [7:0]  got_sum_ff, got_sum_in;

   logic [2:0]  eff_len;
   logic [16:0] elapsed_inc;
   logic        active;
   logic        tick_timeout;
   logic        sync_seen;
   logic        len_match;
   logic        fn_match;
   logic [2:0]  byte_count_inc;
   logic        payload_full;
   logic        tail_ok;
   logic        sum_ok;

   assign eff_len = ({1'b0, cfg.payload_len} > ucfe_pkg::PAYLOAD_MAX) ?
                    ucfe_pkg::PAYLOAD_MAX[2:0] : cfg.payload_len;
   assign elapsed_inc = (elapsed_ff == ucfe_pkg::ELAPSED_MAX) ?
                        elapsed_ff : elapsed_ff + 17'd1;
   assign active = (phase_ff != ucfe_pkg::PH_IDLE);
   // Before sync the reply limit applies, after sync the abort window.
   assign tick_timeout = (phase_ff == ucfe_pkg::PH_HUNT) ?
                         (elapsed_inc > {1'b0, cfg.reply_timeout_ms}) :
                         (elapsed_inc > {1'b0, cfg.abort_window_ms});
   assign sync_seen = (prev_byte_ff == ucfe_pkg::SYNC_BYTE) &&
                      (rx_byte == ucfe_pkg::SYNC_BYTE);
   assign len_match = (length_ff == ({5'd0, eff_len} + ucfe_pkg::LEN_OVERHEAD));
   assign fn_match = (rx_byte == pending_fn_ff);
   assign byte_count_inc = byte_count_ff + 3'd1;
   assign payload_full = (byte_count_inc >= eff_len);
   assign tail_ok = (rx_byte == ucfe_pkg::TAIL_BYTE);
   assign sum_ok = (got_sum_ff == sum_acc_ff);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_type == ucfe_pkg::REQ_SEND) begin
            phase_in = ucfe_pkg::PH_HUNT;
         end else if (active && req_type == ucfe_pkg::REQ_TICK) begin
            if (tick_timeout) phase_in = ucfe_pkg::PH_IDLE;
         end else if (active && req_type == ucfe_pkg::REQ_BYTE) begin
            case (phase_ff)
               ucfe_pkg::PH_HUNT: begin
                  if (sync_seen) phase_in = ucfe_pkg::PH_LEN;
               end
               ucfe_pkg::PH_LEN: begin
                  phase_in = ucfe_pkg::PH_FUNC;
               end
               ucfe_pkg::PH_FUNC: begin
                  if (!len_match || !fn_match) phase_in = ucfe_pkg::PH_IDLE;
                  else if (eff_len == 3'd0) phase_in = ucfe_pkg::PH_SUM;
                  else phase_in = ucfe_pkg::PH_PAYLOAD;
               end
               ucfe_pkg::PH_PAYLOAD: begin
                  if (payload_full) phase_in = ucfe_pkg::PH_SUM;
               end
               ucfe_pkg::PH_SUM: begin
                  phase_in = ucfe_pkg::PH_TAIL;
               end
               default: begin
                  phase_in = ucfe_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   // Datapath and result descriptor
   always_comb begin
      prev_byte_in   = prev_byte_ff;
      pending_fn_in  = pending_fn_ff;
      length_in      = length_ff;
      elapsed_in     = elapsed_ff;
      payload_acc_in = payload_acc_ff;
      byte_count_in  = byte_count_ff;
      sum_acc_in     = sum_acc_ff;
      got_sum_in     = got_sum_ff;
      desc               = '0;
      desc.func_code     = func_code;
      desc.cmd_word      = cmd_word;
      desc.payload_count = byte_count_ff;
      if (accept) begin
         if (req_type == ucfe_pkg::REQ_SEND) begin
            desc.frame     = 1'b1;
            prev_byte_in   = 8'd0;
            pending_fn_in  = func_code;
            length_in      = 8'd0;
            elapsed_in     = 17'd0;
            payload_acc_in = 32'd0;
            byte_count_in  = 3'd0;
            sum_acc_in     = 8'd0;
            got_sum_in     = 8'd0;
         end else if (active && req_type == ucfe_pkg::REQ_TICK) begin
            elapsed_in = elapsed_inc;
            if (tick_timeout) begin
               desc.done   = 1'b1;
               desc.status = (phase_ff == ucfe_pkg::PH_HUNT) ?
                             ucfe_pkg::ST_SYNC_TO : ucfe_pkg::ST_READ_TO;
            end
         end else if (active && req_type == ucfe_pkg::REQ_BYTE) begin
            case (phase_ff)
               ucfe_pkg::PH_HUNT: begin
                  prev_byte_in = rx_byte;
                  if (sync_seen) elapsed_in = 17'd0;
               end
               ucfe_pkg::PH_LEN: begin
                  length_in = rx_byte;
               end
               ucfe_pkg::PH_FUNC: begin
                  if (!len_match) begin
                     desc.done   = 1'b1;
                     desc.status = ucfe_pkg::ST_SIZE;
                  end else if (!fn_match) begin
                     desc.done   = 1'b1;
                     desc.status = ucfe_pkg::ST_FUNCTION;
                  end else begin
                     sum_acc_in     = length_ff + rx_byte;
                     payload_acc_in = 32'd0;
                     byte_count_in  = 3'd0;
                  end
               end
               ucfe_pkg::PH_PAYLOAD: begin
                  payload_acc_in = {payload_acc_ff[23:0], rx_byte};
                  sum_acc_in     = sum_acc_ff + rx_byte;
                  byte_count_in  = byte_count_inc;
               end
               ucfe_pkg::PH_SUM: begin
                  got_sum_in = rx_byte;
               end
               default: begin
                  desc.done = 1'b1;
                  if (!tail_ok) begin
                     desc.status = ucfe_pkg::ST_BAD_TAIL;
                  end else if (!sum_ok) begin
                     desc.status = ucfe_pkg::ST_CHECKSUM;
                  end else begin
                     desc.status       = ucfe_pkg::ST_OK;
                     desc.payload_word = payload_acc_ff;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ucfe_pkg::PH_IDLE;
         prev_byte_ff   <= 8'd0;
         pending_fn_ff  <= 8'd0;
         length_ff      <= 8'd0;
         elapsed_ff     <= 17'd0;
         payload_acc_ff <= 32'd0;
         byte_count_ff  <= 3'd0;
         sum_acc_ff     <= 8'd0;
         got_sum_ff     <= 8'd0;
      end else begin
         phase_ff       <= phase_in;
         prev_byte_ff   <= prev_byte_in;
         pending_fn_ff  <= pending_fn_in;
         length_ff      <= length_in;
         elapsed_ff     <= elapsed_in;
         payload_acc_ff <= payload_acc_in;
         byte_count_ff  <= byte_count_in;
         sum_acc_ff     <= sum_acc_in;
         got_sum_ff     <= got_sum_in;
      end
   end

   a_done_then_idle: assert property (@(posedge clock) disable iff (reset)
      desc.done |=> phase_ff == ucfe_pkg::PH_IDLE)
      else $error("parser not idle after completion");

   a_done_needs_reply: assert property (@(posedge clock) disable iff (reset)
      desc.done |-> phase_ff != ucfe_pkg::PH_IDLE)
      else $error("completion while idle");

   a_ok_only_at_tail: assert property (@(posedge clock) disable iff (reset)
      (desc.done && desc.status == ucfe_pkg::ST_OK) |-> phase_ff == ucfe_pkg::PH_TAIL)
      else $error("ok status outside tail");

   a_send_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == ucfe_pkg::REQ_SEND) |=>
         (phase_ff == ucfe_pkg::PH_HUNT && elapsed_ff == 17'd0))
      else $error("send did not restart the hunt");

endmodule

// ===== hw/rtl/ucfe_serializer.sv =====
// Result register and frame serializer for the serial command frame engine.
// Depends on ucfe_pkg; emits eight frame bytes or one completion per load.
module ucfe_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  ucfe_pkg::desc_type desc,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_is_last,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_payload_word,
   output logic [2:0]         rsp_payload_count
);

   logic        busy_ff, busy_in;
   logic        frame_ff, frame_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  fn_ff, fn_in;
   logic [15:0] word_ff, word_in;
   logic [7:0]  sum_ff, sum_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] payload_ff, payload_in;
   logic [2:0]  count_ff, count_in;

   logic take;
   logic last_out;
   logic [7:0] frame_byte;

   assign take     = busy_ff && !rsp_stall;
   assign last_out = !frame_ff || (idx_ff == ucfe_pkg::POS_TAIL);
   // Free when empty or when the last result leaves this cycle.
   assign free     = !busy_ff || (take && last_out);

   always_comb begin
      case (idx_ff)
         ucfe_pkg::POS_SYNC0: frame_byte = ucfe_pkg::SYNC_BYTE;
         ucfe_pkg::POS_SYNC1: frame_byte = ucfe_pkg::SYNC_BYTE;
         ucfe_pkg::POS_LEN:   frame_byte = ucfe_pkg::CMD_LEN_BYTE;
         ucfe_pkg::POS_FUNC:  frame_byte = fn_ff;
         ucfe_pkg::POS_DH:    frame_byte = word_ff[15:8];
         ucfe_pkg::POS_DL:    frame_byte = word_ff[7:0];
         ucfe_pkg::POS_SUM:   frame_byte = sum_ff;
         default:             frame_byte = ucfe_pkg::TAIL_BYTE;
      endcase
   end

   assign rsp_valid         = busy_ff;
   assign rsp_result_kind   = frame_ff ? ucfe_pkg::KIND_TX : ucfe_pkg::KIND_DONE;
   assign rsp_tx_byte       = frame_ff ? frame_byte : 8'd0;
   assign rsp_is_last       = frame_ff && (idx_ff == ucfe_pkg::POS_TAIL);
   assign rsp_status        = frame_ff ? ucfe_pkg::ST_OK : status_ff;
   assign rsp_payload_word  = frame_ff ? 32'd0 : payload_ff;
   assign rsp_payload_count = frame_ff ? 3'd0 : count_ff;

   always_comb begin
      busy_in    = busy_ff;
      frame_in   = frame_ff;
      idx_in     = idx_ff;
      fn_in      = fn_ff;
      word_in    = word_ff;
      sum_in     = sum_ff;
      status_in  = status_ff;
      payload_in = payload_ff;
      count_in   = count_ff;
      if (load) begin
         busy_in    = 1'b1;
         frame_in   = desc.frame;
         idx_in     = ucfe_pkg::POS_SYNC0;
         fn_in      = desc.func_code;
         word_in    = desc.cmd_word;
         sum_in     = ucfe_pkg::CMD_LEN_BYTE + desc.func_code +
                      desc.cmd_word[15:8] + desc.cmd_word[7:0];
         status_in  = desc.status;
         payload_in = desc.payload_word;
         count_in   = desc.payload_count;
      end else if (take) begin
         // advance through the frame, drop the item after its last result
         if (last_out) busy_in = 1'b0;
         else idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         frame_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         busy_ff  <= busy_in;
         frame_ff <= frame_in;
         idx_ff   <= idx_in;
      end
      fn_ff      <= fn_in;
      word_ff    <= word_in;
      sum_ff     <= sum_in;
      status_ff  <= status_in;
      payload_ff <= payload_in;
      count_ff   <= count_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result register overwritten");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !frame_ff) |-> idx_ff == ucfe_pkg::POS_SYNC0)
      else $error("completion with frame position");

   a_frame_advances: assert property (@(posedge clock) disable iff (reset)
      (take && !last_out) |=> (busy_ff && idx_ff == $past(idx_ff) + 3'd1))
      else $error("frame position did not advance");

endmodule

// ===== hw/rtl/uart_command_frame_engine_core.sv =====
// Timing: a completion appears in the cycle after its item; a send gives its
// first frame byte the next cycle and then one byte per cycle without stall.
// Throughput: one item per cycle while rsp_stall is low, except that a send
// holds req_stall while its remaining frame bytes occupy the result register.
// Reset (synchronous, active high) empties the result register, puts the
// parser in idle and loads the register defaults 40 ms, 10 ms and 4 bytes.
module uart_command_frame_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_func_code,
   input  logic [15:0] req_cmd_word,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_is_last,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_payload_word,
   output logic [2:0]  rsp_payload_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ucfe_pkg::cfg_type  cfg_ff, cfg_in;
   ucfe_pkg::desc_type desc;
   logic accept;
   logic free;
   logic load;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ucfe_pkg::CSR_REPLY_TIMEOUT: cfg_in.reply_timeout_ms = csr_wdata;
            ucfe_pkg::CSR_ABORT_WINDOW:  cfg_in.abort_window_ms  = csr_wdata;
            ucfe_pkg::CSR_PAYLOAD_LEN:   cfg_in.payload_len      = csr_wdata[2:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reply_timeout_ms <= 16'd40;
         cfg_ff.abort_window_ms  <= 16'd10;
         cfg_ff.payload_len      <= 3'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = !free;
   assign accept    = req_valid && !req_stall;
   assign load      = desc.frame || desc.done;

   ucfe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_type),
      .func_code (req_func_code),
      .cmd_word  (req_cmd_word),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .desc      (desc)
   );

   ucfe_serializer u_serializer (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .desc              (desc),
      .free              (free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_is_last       (rsp_is_last),
      .rsp_status        (rsp_status),
      .rsp_payload_word  (rsp_payload_word),
      .rsp_payload_count (rsp_payload_count)
   );

endmodule
